// ===== hw/rtl/tvc_pkg.sv =====
// ----------------------------------------------------------------------------
// tvc_pkg
// Shared types, character codes and result codes of the text value type
// classifier.
// ----------------------------------------------------------------------------
package tvc_pkg;

	localparam int unsigned CH_W   = 16;
	localparam int unsigned CODE_W = 2;
	localparam int unsigned POS_W  = 3;

	// Result codes.
	localparam logic [CODE_W-1:0] CODE_BOOL   = 2'd0;
	localparam logic [CODE_W-1:0] CODE_INT    = 2'd1;
	localparam logic [CODE_W-1:0] CODE_FLOAT  = 2'd2;
	localparam logic [CODE_W-1:0] CODE_STRING = 2'd3;

	// Character codes that steer the scan.
	localparam logic [CH_W-1:0] CH_LPAREN = 16'h0028;
	localparam logic [CH_W-1:0] CH_RPAREN = 16'h0029;
	localparam logic [CH_W-1:0] CH_COMMA  = 16'h002C;
	localparam logic [CH_W-1:0] CH_MINUS  = 16'h002D;
	localparam logic [CH_W-1:0] CH_DOT    = 16'h002E;
	localparam logic [CH_W-1:0] CH_ZERO   = 16'h0030;
	localparam logic [CH_W-1:0] CH_NINE   = 16'h0039;

	localparam logic [POS_W-1:0] POS_MAX     = 3'd7;
	localparam logic [POS_W-1:0] TRUE_LEN    = 3'd4;
	localparam logic [POS_W-1:0] FALSE_LEN   = 3'd5;

	// Result of the scanner for the beat it is looking at.
	typedef struct packed {
		logic              fire;
		logic [CODE_W-1:0] code;
	} tvc_result_t;

	// Expected character of "true" at a given position.
	function automatic logic [CH_W-1:0] true_char(input logic [1:0] p);
		logic [CH_W-1:0] c;
		case (p)
			2'd0:    c = 16'h0074;
			2'd1:    c = 16'h0072;
			2'd2:    c = 16'h0075;
			default: c = 16'h0065;
		endcase
		return c;
	endfunction

	// Expected character of "false" at a given position (0 to 4).
	function automatic logic [CH_W-1:0] false_char(input logic [POS_W-1:0] p);
		logic [CH_W-1:0] c;
		case (p)
			3'd0:    c = 16'h0066;
			3'd1:    c = 16'h0061;
			3'd2:    c = 16'h006C;
			3'd3:    c = 16'h0073;
			3'd4:    c = 16'h0065;
			default: c = 16'h0066;
		endcase
		return c;
	endfunction

endpackage

// ===== hw/rtl/tvc_scan.sv =====
// ----------------------------------------------------------------------------
// tvc_scan
// Per-value scan state and the flag update logic for one character beat.
// ----------------------------------------------------------------------------
module tvc_scan (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic [tvc_pkg::CH_W-1:0]     ch,
	input  logic                         last,
	input  logic                         empty_req,
	output tvc_pkg::tvc_result_t         result
);

	typedef enum logic [1:0] {
		SCAN_OPEN   = 2'd0,
		SCAN_STRING = 2'd1,
		SCAN_CLOSED = 2'd2
	} verdict_t;

	logic [tvc_pkg::POS_W-1:0] position_q, position_d;
	logic                      true_match_q, true_match_d;
	logic                      false_match_q, false_match_d;
	logic                      bracket_open_q, bracket_open_d;
	logic                      dot_seen_q, dot_seen_d;
	logic                      sign_seen_q, sign_seen_d;
	logic                      several_q, several_d;
	verdict_t                  verdict_q, verdict_d;
	logic                      is_digit;
	logic                      clear;

	assign is_digit = ch inside {[tvc_pkg::CH_ZERO:tvc_pkg::CH_NINE]};
	assign clear    = empty_req || last;

	// Flags after this character is taken into account.
	always_comb begin
		true_match_d   = true_match_q && (position_q < tvc_pkg::TRUE_LEN) &&
			(ch == tvc_pkg::true_char(position_q[1:0]));
		false_match_d  = false_match_q && (position_q < tvc_pkg::FALSE_LEN) &&
			(ch == tvc_pkg::false_char(position_q));
		position_d     = (position_q == tvc_pkg::POS_MAX) ? position_q :
			position_q + 3'd1;
		bracket_open_d = bracket_open_q;
		dot_seen_d     = dot_seen_q;
		sign_seen_d    = sign_seen_q;
		several_d      = several_q;
		verdict_d      = verdict_q;
		if (verdict_q == SCAN_OPEN) begin
			if (position_q == '0 && ch == tvc_pkg::CH_LPAREN) begin
				bracket_open_d = 1'b1;
			end else if (is_digit) begin
				verdict_d = verdict_q;
			end else if (ch == tvc_pkg::CH_DOT) begin
				if (dot_seen_q) verdict_d = SCAN_STRING;
				else dot_seen_d = 1'b1;
			end else if (ch == tvc_pkg::CH_MINUS) begin
				if (sign_seen_q) verdict_d = SCAN_STRING;
				else sign_seen_d = 1'b1;
			end else if (ch == tvc_pkg::CH_COMMA) begin
				several_d   = 1'b1;
				dot_seen_d  = 1'b0;
				sign_seen_d = 1'b0;
			end else if (ch == tvc_pkg::CH_RPAREN) begin
				verdict_d = bracket_open_q ? SCAN_CLOSED : SCAN_STRING;
			end else begin
				verdict_d = SCAN_STRING;
			end
		end
	end

	// Verdict for a value that ends on this beat.
	always_comb begin
		result.fire = clear;
		if (empty_req) begin
			result.code = tvc_pkg::CODE_STRING;
		end else if ((true_match_d && position_d == tvc_pkg::TRUE_LEN) ||
				(false_match_d && position_d == tvc_pkg::FALSE_LEN)) begin
			result.code = tvc_pkg::CODE_BOOL;
		end else if (verdict_d != SCAN_OPEN && verdict_d != SCAN_CLOSED) begin
			result.code = tvc_pkg::CODE_STRING;
		end else if (several_d) begin
			result.code = tvc_pkg::CODE_STRING;
		end else begin
			result.code = dot_seen_d ? tvc_pkg::CODE_FLOAT : tvc_pkg::CODE_INT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			position_q     <= '0;
			true_match_q   <= 1'b1;
			false_match_q  <= 1'b1;
			bracket_open_q <= 1'b0;
			dot_seen_q     <= 1'b0;
			sign_seen_q    <= 1'b0;
			several_q      <= 1'b0;
			verdict_q      <= SCAN_OPEN;
		end else if (en) begin
			if (clear) begin
				position_q     <= '0;
				true_match_q   <= 1'b1;
				false_match_q  <= 1'b1;
				bracket_open_q <= 1'b0;
				dot_seen_q     <= 1'b0;
				sign_seen_q    <= 1'b0;
				several_q      <= 1'b0;
				verdict_q      <= SCAN_OPEN;
			end else begin
				position_q     <= position_d;
				true_match_q   <= true_match_d;
				false_match_q  <= false_match_d;
				bracket_open_q <= bracket_open_d;
				dot_seen_q     <= dot_seen_d;
				sign_seen_q    <= sign_seen_d;
				several_q      <= several_d;
				verdict_q      <= verdict_d;
			end
		end
	end

endmodule

// ===== hw/rtl/text_value_type_classifier_unit.sv =====
// ----------------------------------------------------------------------------
// text_value_type_classifier_unit
// Classifies a streamed text value as bool, int, float or string.
// ----------------------------------------------------------------------------
// Usage:
// Each input beat on in_valid/in_ready carries one character code (ch) of a
// text value; last marks its final character, and empty_req stands for a
// whole empty value (ch and last are then ignored). Beats without last or
// empty_req produce no output. The beat that ends a value produces exactly
// one output beat on out_valid/out_ready carrying type_code (0 bool, 1 int,
// 2 float, 3 string).
// A beat accepted into the input register is scanned there; the result of
// a value-ending beat goes to the output register. Throughput is one beat
// per cycle unless a stalled output holds back a value-ending beat; the
// scan state update is a single level of compares and flag logic.
// When the receiver stalls, the result waits in the output register and the
// input register still takes a beat; a further value-ending beat then holds
// in the input register and in_ready drops until the output drains. Beats
// that end no value keep flowing past a stalled output.
// Reset clears the valid flags and returns the scan state to the start of a
// value.
// ----------------------------------------------------------------------------
module text_value_type_classifier_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [tvc_pkg::CH_W-1:0]     ch,
	input  logic                         last,
	input  logic                         empty_req,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [tvc_pkg::CODE_W-1:0]   type_code
);

	logic                         valid_s1;
	logic [tvc_pkg::CH_W-1:0]     ch_s1;
	logic                         last_s1;
	logic                         empty_s1;
	logic                         out_valid_q;
	logic [tvc_pkg::CODE_W-1:0]   type_code_q;
	logic                         out_free;
	logic                         advance_s1;
	tvc_pkg::tvc_result_t         result;

	// The output slot can take a new result when it is empty or draining.
	assign out_free   = !out_valid_q || out_ready;
	// The held beat moves on unless it carries a result with nowhere to go.
	assign advance_s1 = valid_s1 && (!result.fire || out_free);
	assign in_ready   = !valid_s1 || advance_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			ch_s1    <= ch;
			last_s1  <= last;
			empty_s1 <= empty_req;
		end
	end

	tvc_scan u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (advance_s1),
		.ch        (ch_s1),
		.last      (last_s1),
		.empty_req (empty_s1),
		.result    (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= advance_s1 && result.fire;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && advance_s1 && result.fire) begin
			type_code_q <= result.code;
		end
	end

	assign out_valid = out_valid_q;
	assign type_code = type_code_q;

endmodule

// ===== verif/text_value_type_classifier_unit_tb.sv =====
// ----------------------------------------------------------------------------
// text_value_type_classifier_unit_tb
// Streams text values into the classifier one character beat at a time and
// checks each reported type against a cycle-free predictor of the scan.
// Directed values cover the keywords, bracket, sign, dot and comma handling,
// empty values and long values. Random values then follow, mostly numbers
// with random content, plus keyword variants and noise. Both handshakes idle
// at random, and one long receiver hold-off fills the block up.
// ----------------------------------------------------------------------------
module text_value_type_classifier_unit_tb;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned CH_W         = tvc_pkg::CH_W;
	localparam int unsigned CODE_W       = tvc_pkg::CODE_W;
	localparam int unsigned POS_W        = tvc_pkg::POS_W;
	localparam int unsigned RANDOM_BEATS = 770;
	localparam int unsigned CYCLE_LIMIT  = 100000;
	localparam int unsigned DRAIN_CYCLES = 16;
	localparam logic [31:0] WORD_TRUE    = "true";
	localparam logic [39:0] WORD_FALSE   = "false";

	typedef enum logic [1:0] {
		SCAN_OPEN,
		SCAN_STRING,
		SCAN_CLOSED
	} scan_e;

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_ready;
	logic [CH_W-1:0]   ch;
	logic              last;
	logic              empty_req;
	logic              out_valid;
	logic              out_ready;
	logic [CODE_W-1:0] type_code;

	// Scan state of the value currently being streamed in.
	logic [POS_W-1:0]  chars_seen;
	logic              maybe_true;
	logic              maybe_false;
	logic              in_brackets;
	logic              num_has_dot;
	logic              num_has_sign;
	logic              many_numbers;
	scan_e             scan_state;

	logic [CODE_W-1:0] expected_codes[$];
	logic [CH_W-1:0]   text_buf[$];

	int unsigned       error_count;
	int unsigned       cycle_count;
	int unsigned       beats_sent;
	int unsigned       tx_idle_pct;
	int unsigned       rx_idle_pct;
	int unsigned       hold_left;

	text_value_type_classifier_unit DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.ch        (ch),
		.last      (last),
		.empty_req (empty_req),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.type_code (type_code)
	);

	always #6 clk = ~clk;

	// Cycle counter that ends a hung run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("text_value_type_classifier_unit: mismatch");
			$finish;
		end
	end

	// Receiver: random stalls, or a solid hold-off while hold_left runs down.
	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left = hold_left - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	task automatic report_mismatch(input string msg);
		$display("ERROR @%0t: %s", $realtime, msg);
		error_count++;
	endtask

	// Every accepted result beat is checked against the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_codes.size() == 0) begin
				report_mismatch($sformatf("result beat %0d with nothing expected", type_code));
			end else if (type_code !== expected_codes[0]) begin
				report_mismatch($sformatf("type_code %0d, expected %0d",
					type_code, expected_codes[0]));
				void'(expected_codes.pop_front());
			end else begin
				void'(expected_codes.pop_front());
			end
		end
	end

	task automatic clear_scan();
		chars_seen   = '0;
		maybe_true   = 1'b1;
		maybe_false  = 1'b1;
		in_brackets  = 1'b0;
		num_has_dot  = 1'b0;
		num_has_sign = 1'b0;
		many_numbers = 1'b0;
		scan_state   = SCAN_OPEN;
	endtask

	// Advances the scan by one accepted beat. When the beat ends a value,
	// done is set and code holds the type of the whole value.
	task automatic classify_beat(input logic [CH_W-1:0] c, input logic is_last,
			input logic is_empty, output bit done, output logic [CODE_W-1:0] code);
		logic [POS_W-1:0] p;
		int               ti;
		int               fi;
		p    = chars_seen;
		done = 1'b0;
		code = tvc_pkg::CODE_STRING;
		if (is_empty) begin
			clear_scan();
			done = 1'b1;
			return;
		end
		ti = 3 - int'(p[1:0]);
		fi = (p < 5) ? 4 - int'(p) : 4;
		maybe_true  = maybe_true && (p < 4) && (c == {8'h00, WORD_TRUE[8*ti +: 8]});
		maybe_false = maybe_false && (p < 5) && (c == {8'h00, WORD_FALSE[8*fi +: 8]});
		// Once the scan is decided or closed, later characters no longer change the number flags or the verdict.
		if (scan_state == SCAN_OPEN) begin
			if (p == 0 && c == tvc_pkg::CH_LPAREN) begin
				in_brackets = 1'b1;
			end else if (!(c inside {[tvc_pkg::CH_ZERO:tvc_pkg::CH_NINE]})) begin
				case (c)
					tvc_pkg::CH_DOT: begin
						if (num_has_dot) scan_state = SCAN_STRING;
						else num_has_dot = 1'b1;
					end
					tvc_pkg::CH_MINUS: begin
						if (num_has_sign) scan_state = SCAN_STRING;
						else num_has_sign = 1'b1;
					end
					tvc_pkg::CH_COMMA: begin
						many_numbers = 1'b1;
						num_has_dot  = 1'b0;
						num_has_sign = 1'b0;
					end
					tvc_pkg::CH_RPAREN: begin
						scan_state = in_brackets ? SCAN_CLOSED : SCAN_STRING;
					end
					default: begin
						scan_state = SCAN_STRING;
					end
				endcase
			end
		end
		if (p != tvc_pkg::POS_MAX) chars_seen = p + 1'b1;
		if (is_last) begin
			done = 1'b1;
			if ((maybe_true && chars_seen == tvc_pkg::TRUE_LEN) ||
					(maybe_false && chars_seen == tvc_pkg::FALSE_LEN)) begin
				code = tvc_pkg::CODE_BOOL;
			end else if (scan_state == SCAN_STRING || many_numbers) begin
				code = tvc_pkg::CODE_STRING;
			end else begin
				code = num_has_dot ? tvc_pkg::CODE_FLOAT : tvc_pkg::CODE_INT;
			end
			clear_scan();
		end
	endtask

	// Offers one beat, holding it until accepted, then updates the prediction.
	// Called at a rising edge; returns at the edge that accepted the beat.
	task automatic send_beat(input logic [CH_W-1:0] c, input logic is_last,
			input logic is_empty);
		bit                done;
		logic [CODE_W-1:0] code;
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		ch        <= c;
		last      <= is_last;
		empty_req <= is_empty;
		do @(posedge clk); while (!in_ready);
		classify_beat(c, is_last, is_empty, done, code);
		if (done) expected_codes.push_back(code);
		beats_sent++;
	endtask

	task automatic send_empty();
		send_beat(CH_W'($urandom_range(16'hFFFF)), 1'($urandom_range(1)), 1'b1);
	endtask

	// Streams text_buf as one value; an empty buffer goes out as an empty value.
	task automatic send_text();
		int i;
		if (text_buf.size() == 0) begin
			send_empty();
			return;
		end
		for (i = 0; i < text_buf.size(); i++) begin
			send_beat(text_buf[i], i == text_buf.size() - 1, 1'b0);
		end
	endtask

	task automatic load_string(input string s);
		int i;
		text_buf.delete();
		for (i = 0; i < s.len(); i++) text_buf.push_back({8'h00, s[i]});
	endtask

	task automatic send_string(input string s);
		load_string(s);
		send_text();
	endtask

	function automatic logic [CH_W-1:0] pick_char();
		logic [CH_W-1:0] c;
		case ($urandom_range(11))
			0, 1, 2: c = tvc_pkg::CH_ZERO + CH_W'($urandom_range(9));
			3:       c = tvc_pkg::CH_DOT;
			4:       c = tvc_pkg::CH_MINUS;
			5:       c = tvc_pkg::CH_COMMA;
			6:       c = tvc_pkg::CH_LPAREN;
			7:       c = tvc_pkg::CH_RPAREN;
			8:       c = {8'h00, WORD_TRUE[8*$urandom_range(3) +: 8]};
			9:       c = {8'h00, WORD_FALSE[8*$urandom_range(4) +: 8]};
			10:      c = '0;
			default: c = CH_W'($urandom_range(16'hFFFF));
		endcase
		return c;
	endfunction

	// Appends one number: digits with an optional sign and dot, and now and
	// then a second dot or sign to break it.
	task automatic add_number(input int unsigned max_len);
		int len;
		int i;
		int dot_at;
		int minus_at;
		len      = $urandom_range(max_len);
		dot_at   = ($urandom_range(99) < 40) ? int'($urandom_range(len)) : -1;
		minus_at = ($urandom_range(99) < 40) ?
			(($urandom_range(99) < 70) ? 0 : int'($urandom_range(len))) : -1;
		for (i = 0; i <= len; i++) begin
			if (i == minus_at) text_buf.push_back(tvc_pkg::CH_MINUS);
			if (i == dot_at) text_buf.push_back(tvc_pkg::CH_DOT);
			if (i < len) text_buf.push_back(tvc_pkg::CH_ZERO + CH_W'($urandom_range(9)));
		end
		if ($urandom_range(99) < 6) text_buf.push_back(tvc_pkg::CH_DOT);
		if ($urandom_range(99) < 6) text_buf.push_back(tvc_pkg::CH_MINUS);
	endtask

	task automatic build_numeric(input int unsigned max_len);
		bit bracketed;
		int n;
		int i;
		text_buf.delete();
		bracketed = ($urandom_range(99) < 50);
		if (bracketed) text_buf.push_back(tvc_pkg::CH_LPAREN);
		n = ($urandom_range(99) < 80) ? 1 : int'($urandom_range(2, 3));
		for (i = 0; i < n; i++) begin
			if (i > 0) text_buf.push_back(tvc_pkg::CH_COMMA);
			add_number(max_len);
		end
		if (bracketed && $urandom_range(99) < 60) begin
			text_buf.push_back(tvc_pkg::CH_RPAREN);
			// Anything after the closing bracket is ignored by the scan.
			if ($urandom_range(99) < 30) begin
				repeat ($urandom_range(1, 3)) text_buf.push_back(pick_char());
			end
		end else if ($urandom_range(99) < 5) begin
			text_buf.push_back(tvc_pkg::CH_RPAREN);
		end
		if (text_buf.size() > 0 && $urandom_range(99) < 8) begin
			text_buf[$urandom_range(text_buf.size() - 1)] = pick_char();
		end
	endtask

	task automatic build_keyword();
		int k;
		load_string(($urandom_range(1) != 0) ? "true" : "false");
		case ($urandom_range(5))
			0, 1: ;
			2: void'(text_buf.pop_back());
			3: text_buf.push_back(pick_char());
			4: begin
				k = $urandom_range(text_buf.size() - 1);
				text_buf[k] = text_buf[k] ^ (CH_W'(1) << $urandom_range(CH_W - 1));
			end
			default: text_buf.push_front(tvc_pkg::CH_LPAREN);
		endcase
	endtask

	task automatic send_random_value();
		int unsigned kind;
		kind = $urandom_range(99);
		if (kind < 35) begin
			build_numeric(4);
		end else if (kind < 50) begin
			build_keyword();
		end else if (kind < 65) begin
			text_buf.delete();
			repeat ($urandom_range(1, 9)) text_buf.push_back(pick_char());
		end else if (kind < 73) begin
			text_buf.delete();
			repeat ($urandom_range(1, 4)) text_buf.push_back(CH_W'($urandom_range(16'hFFFF)));
		end else if (kind < 82) begin
			text_buf.delete();
		end else if (kind < 90) begin
			// A value cut short by an empty request; its characters are dropped.
			build_numeric(3);
			repeat (text_buf.size()) begin
				send_beat(text_buf.pop_front(), 1'b0, 1'b0);
			end
			text_buf.delete();
		end else begin
			// Long numbers push the position counter into saturation.
			build_numeric(12);
		end
		send_text();
	endtask

	task automatic test_keywords();
		send_string("true");
		send_string("false");
	endtask

	task automatic test_number_forms();
		send_string("(-1.)x");
		send_string("1,2");
		send_string("-");
		send_string("(");
		send_string(")");
		send_string("12345678");
	endtask

	task automatic test_special_values();
		send_empty();
		send_beat(tvc_pkg::CH_ZERO + CH_W'(9), 1'b0, 1'b0);
		send_empty();
		send_beat('0, 1'b1, 1'b0);
		send_beat(16'hFFFF, 1'b1, 1'b0);
	endtask

	// Holds the receiver off while single-digit values keep coming, so the
	// output register fills and the input side has to stall.
	task automatic test_output_backpressure();
		tx_idle_pct = 0;
		in_valid <= 1'b0;
		@(negedge clk);
		hold_left = 90;
		@(posedge clk);
		repeat (40) send_beat(tvc_pkg::CH_ZERO + CH_W'($urandom_range(9)), 1'b1, 1'b0);
		tx_idle_pct = 29;
	endtask

	task automatic test_random_values();
		int unsigned start;
		start = beats_sent;
		while (beats_sent - start < RANDOM_BEATS) begin
			// One stretch in the middle runs with neither side idling.
			if (beats_sent - start >= 300 && beats_sent - start < 450) begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end else begin
				tx_idle_pct = 29;
				rx_idle_pct = 29;
			end
			send_random_value();
		end
	endtask

	initial begin
		clk         = 1'b0;
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		ch          = '0;
		last        = 1'b0;
		empty_req   = 1'b0;
		out_ready   = 1'b0;
		error_count = 0;
		cycle_count = 0;
		beats_sent  = 0;
		tx_idle_pct = 29;
		rx_idle_pct = 29;
		hold_left   = 0;
		clear_scan();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_keywords();
		test_number_forms();
		test_special_values();
		test_output_backpressure();
		test_random_values();

		in_valid <= 1'b0;
		while (expected_codes.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0) begin
			$display("text_value_type_classifier_unit: match");
		end else begin
			$display("text_value_type_classifier_unit: mismatch");
		end
		$finish;
	end

endmodule
